>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the UTF-8 structural filter.
// Expects signals clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds whenever trig holds.
`define ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check that cond holds in the cycle after trig.
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/usf_pkg.sv
// Package for the UTF-8 structural filter: byte range constants, lead
// classification and shared types. No dependencies.
package usf_pkg;

  localparam int unsigned MaxBurst = 4;
  localparam int unsigned CntW     = 3;

  localparam logic [7:0] AsciiEnd = 8'h80;
  localparam logic [7:0] ContLo   = 8'h80;
  localparam logic [7:0] ContHi   = 8'hBF;
  localparam logic [7:0] Lead2    = 8'hC0;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;
  localparam logic [7:0] LeadEnd  = 8'hF8;

  localparam logic OpData  = 1'b0;
  localparam logic OpFlush = 1'b1;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_STRAY,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4
  } lead_cls_t;

  typedef logic [7:0] byte_t;
  typedef logic [CntW-1:0] cnt_t;

  function automatic lead_cls_t lead_class(input byte_t b);
    lead_cls_t c;
    if (b < AsciiEnd) begin
      c = CLS_ASCII;
    end else if (b < Lead2) begin
      c = CLS_STRAY;
    end else if (b < Lead3) begin
      c = CLS_LEAD2;
    end else if (b < Lead4) begin
      c = CLS_LEAD3;
    end else if (b < LeadEnd) begin
      c = CLS_LEAD4;
    end else begin
      c = CLS_STRAY;
    end
    return c;
  endfunction

  function automatic logic is_cont(input byte_t b);
    return (b >= ContLo) && (b <= ContHi);
  endfunction

endpackage

>>> rtl/utf8_structural_filter_core.sv
// Top level of the UTF-8 structural filter: sequence tracking and result buffer.
// Depends on usf_pkg and assert_macros.svh.
//
// Takes one byte word per cycle unless stalled, and passes on only structurally
// complete UTF-8 sequences; stray bytes and groups holding a non-continuation
// byte are dropped, and a flush word discards an open sequence. Each accepted
// word is decoded in the cycle it arrives and its results (0 to 4 bytes) load a
// result buffer that drains one byte per cycle while out_stall is low;
// out_last_of_run marks the final byte of a word. The input is stalled until
// the buffer holds at most its last byte being taken. Words that produce zero
// or one byte flow at one per cycle while out_stall is low.
`include "assert_macros.svh"

module utf8_structural_filter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  logic              seq_open_r, seq_open_nxt;
  logic [1:0]        seq_need_r, seq_need_nxt;
  logic [1:0]        seq_have_r, seq_have_nxt;
  logic              seq_bad_r,  seq_bad_nxt;
  usf_pkg::byte_t    seq_bytes_r [3];
  usf_pkg::byte_t    seq_bytes_nxt [3];

  usf_pkg::byte_t    buf_r   [usf_pkg::MaxBurst];
  usf_pkg::byte_t    buf_nxt [usf_pkg::MaxBurst];
  usf_pkg::cnt_t     cnt_r, cnt_nxt;

  usf_pkg::byte_t    burst [usf_pkg::MaxBurst];
  usf_pkg::cnt_t     burst_cnt;
  usf_pkg::lead_cls_t cls;
  logic              in_acc, out_acc;
  logic              bad_upd;
  logic [1:0]        have_inc;

  assign out_valid       = (cnt_r != '0);
  assign out_byte        = buf_r[0];
  assign out_last_of_run = (cnt_r == usf_pkg::cnt_t'(1));
  assign out_acc         = out_valid && !out_stall;
  assign in_stall        = (cnt_r > usf_pkg::cnt_t'(1)) ||
                           ((cnt_r == usf_pkg::cnt_t'(1)) && out_stall);
  assign in_acc          = in_valid && !in_stall;

  assign cls      = usf_pkg::lead_class(in_data_byte);
  assign bad_upd  = seq_bad_r || !usf_pkg::is_cont(in_data_byte);
  assign have_inc = seq_have_r + 2'd1;

  always_comb begin
    seq_open_nxt  = seq_open_r;
    seq_need_nxt  = seq_need_r;
    seq_have_nxt  = seq_have_r;
    seq_bad_nxt   = seq_bad_r;
    seq_bytes_nxt = seq_bytes_r;
    burst_cnt     = '0;
    for (int i = 0; i < usf_pkg::MaxBurst; i++) begin
      burst[i] = in_data_byte;
    end
    if (in_acc) begin
      if (in_op == usf_pkg::OpFlush) begin
        seq_open_nxt = 1'b0;
        seq_need_nxt = '0;
        seq_have_nxt = '0;
        seq_bad_nxt  = 1'b0;
      end else if (seq_open_r) begin
        if (have_inc >= seq_need_r) begin
          for (int i = 0; i < 3; i++) begin
            if (i < int'(seq_need_r)) begin
              burst[i] = seq_bytes_r[i];
            end
          end
          if (!bad_upd) begin
            burst_cnt = usf_pkg::cnt_t'(seq_need_r) + usf_pkg::cnt_t'(1);
          end
          seq_open_nxt = 1'b0;
          seq_need_nxt = '0;
          seq_have_nxt = '0;
          seq_bad_nxt  = 1'b0;
        end else begin
          seq_have_nxt = have_inc;
          seq_bad_nxt  = bad_upd;
          case (have_inc)
            2'd1:    seq_bytes_nxt[1] = in_data_byte;
            2'd2:    seq_bytes_nxt[2] = in_data_byte;
            default: seq_bytes_nxt[0] = seq_bytes_r[0];
          endcase
        end
      end else begin
        case (cls)
          usf_pkg::CLS_ASCII: begin
            burst_cnt = usf_pkg::cnt_t'(1);
          end
          usf_pkg::CLS_LEAD2, usf_pkg::CLS_LEAD3, usf_pkg::CLS_LEAD4: begin
            seq_open_nxt     = 1'b1;
            seq_have_nxt     = '0;
            seq_bad_nxt      = 1'b0;
            seq_bytes_nxt[0] = in_data_byte;
            seq_bytes_nxt[1] = '0;
            seq_bytes_nxt[2] = '0;
            if (cls == usf_pkg::CLS_LEAD2) begin
              seq_need_nxt = 2'd1;
            end else if (cls == usf_pkg::CLS_LEAD3) begin
              seq_need_nxt = 2'd2;
            end else begin
              seq_need_nxt = 2'd3;
            end
          end
          default: begin
            seq_open_nxt = seq_open_r;
          end
        endcase
      end
    end
  end

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      buf_nxt = burst;
      cnt_nxt = burst_cnt;
    end else if (out_acc) begin
      for (int i = 0; i < usf_pkg::MaxBurst - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - usf_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_open_r <= 1'b0;
      seq_need_r <= '0;
      seq_have_r <= '0;
      seq_bad_r  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      seq_open_r <= seq_open_nxt;
      seq_need_r <= seq_need_nxt;
      seq_have_r <= seq_have_nxt;
      seq_bad_r  <= seq_bad_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_bytes_r <= seq_bytes_nxt;
    buf_r       <= buf_nxt;
  end

  `ASSERT_SAME(a_closed_clean, !seq_open_r, (seq_have_r == 2'd0) && !seq_bad_r,
               "closed sequence holds stale state")
  `ASSERT_SAME(a_open_short, seq_open_r,
               (seq_have_r < seq_need_r) && (seq_need_r != 2'd0),
               "open sequence already full")
  `ASSERT_SAME(a_cnt_range, 1'b1, cnt_r <= usf_pkg::cnt_t'(usf_pkg::MaxBurst),
               "result buffer count out of range")
  `ASSERT_NEXT(a_drain_empty, out_acc && out_last_of_run && !in_acc, !out_valid,
               "result buffer not empty after last byte")

endmodule
